### rtl/core/abr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// abr_pkg: shared types for the alternate block reverser
// Command format between the front and back parts, and the result word.
// ---------------------------------------------------------------------------
package abr_pkg;

    localparam int VALUE_W   = 32;
    localparam int SIZE_W    = 5;
    // Wide enough for a block count at the largest supported block size.
    localparam int CNT_MAX_W = 7;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_REV,
        CMD_FWD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic                        last;
        logic                        bank;
        logic [CNT_MAX_W-1:0]        count;
        logic signed [VALUE_W-1:0]   value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_done_t;

    typedef struct packed {
        logic                        last;
        logic signed [VALUE_W-1:0]   value;
    } result_t;

endpackage
`default_nettype wire

### rtl/core/abr_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// abr_fifo: small register queue
// Push/pop queue with head data shown combinationally and an occupancy count.
// ---------------------------------------------------------------------------
module abr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int PTR_W = 1,
    parameter int CNT_W = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty,
    output logic                  full,
    output logic      [CNT_W-1:0] count
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign count   = count_reg;
    assign rd_data = entry_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### rtl/core/abr_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// abr_front: input side of the block reverser
// Tracks block phase and fill, writes reversed-phase items into a two-bank
// store, and issues one command per reversed-phase block and per passed item.
// ---------------------------------------------------------------------------
module abr_front #(
    parameter int MAX_BLOCK = 16,
    parameter int CNT_W     = 5,
    parameter int IDX_W     = 4,
    parameter int ADDR_W    = 5
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    input  wire logic signed [abr_pkg::VALUE_W-1:0]    value,
    input  wire logic                                  last,
    output logic                                       full,
    input  wire logic [CNT_W-1:0]                      size,
    input  wire logic                                  cmd_full,
    output logic                                       cmd_push,
    output abr_pkg::cmd_t                              cmd,
    input  wire abr_pkg::bank_done_t                   done,
    output logic                                       wr_en,
    output logic [ADDR_W-1:0]                          wr_addr,
    output logic [abr_pkg::VALUE_W-1:0]                wr_data
);

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             phase_reg, phase_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic [CNT_W-1:0] fill_inc;
    logic             closes;
    logic             accept;
    logic             dispatch;

    // A reversed-phase item must wait until its bank has been drained.
    assign full     = cmd_full | (phase_reg & busy_reg[bank_reg]);
    assign accept   = push & ~full;
    assign fill_inc = fill_reg + CNT_W'(1);
    assign closes   = (fill_inc >= size);
    assign wr_addr  = ADDR_W'(fill_reg[IDX_W-1:0])
                    + (bank_reg ? ADDR_W'(MAX_BLOCK) : ADDR_W'(0));
    assign wr_data  = value;

    always_comb
    begin
        fill_next  = fill_reg;
        phase_next = phase_reg;
        bank_next  = bank_reg;
        wr_en      = 1'b0;
        cmd_push   = 1'b0;
        dispatch   = 1'b0;
        cmd.kind   = abr_pkg::CMD_PASS;
        cmd.last   = last;
        cmd.bank   = bank_reg;
        cmd.count  = abr_pkg::CNT_MAX_W'(fill_inc);
        cmd.value  = value;
        if (accept)
        begin
            if (phase_reg)
            begin
                wr_en = 1'b1;
                if (closes || last)
                begin
                    cmd_push  = 1'b1;
                    dispatch  = 1'b1;
                    cmd.kind  = closes ? abr_pkg::CMD_REV : abr_pkg::CMD_FWD;
                    bank_next = ~bank_reg;
                end
                if (closes)
                begin
                    fill_next  = '0;
                    phase_next = 1'b0;
                end
                else
                begin
                    fill_next = fill_inc;
                end
            end
            else
            begin
                cmd_push  = 1'b1;
                // A passed item always plays out as a single result.
                cmd.count = abr_pkg::CNT_MAX_W'(1);
                if (closes)
                begin
                    fill_next  = '0;
                    phase_next = 1'b1;
                end
                else
                begin
                    fill_next = fill_inc;
                end
            end
            // The end of a sequence starts the next one from the reset phase.
            if (last)
            begin
                fill_next  = '0;
                phase_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (done.valid)
        begin
            busy_next[done.bank] = 1'b0;
        end
        if (dispatch)
        begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            phase_reg <= 1'b1;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CNT_W'(MAX_BLOCK))
        else $error("block fill count reached the store depth");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> phase_reg && fill_reg == '0)
        else $error("sequence end did not restart block state");

    a_no_write_busy_bank: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !busy_reg[bank_reg])
        else $error("write into a bank still being drained");

endmodule
`default_nettype wire

### rtl/core/abr_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// abr_back: output side of the block reverser
// Holds the two-bank block store and plays out each command, one result per
// cycle when the result queue has room, reading the store backward or forward.
// ---------------------------------------------------------------------------
module abr_back #(
    parameter int MAX_BLOCK = 16,
    parameter int CNT_W     = 5,
    parameter int IDX_W     = 4,
    parameter int ADDR_W    = 5,
    parameter int OUT_DEPTH = 4,
    parameter int OCNT_W    = 3
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_empty,
    input  wire abr_pkg::cmd_t                 cmd,
    output logic                               cmd_pop,
    output abr_pkg::bank_done_t                done,
    input  wire logic                          wr_en,
    input  wire logic [ADDR_W-1:0]             wr_addr,
    input  wire logic [abr_pkg::VALUE_W-1:0]   wr_data,
    input  wire logic [OCNT_W-1:0]             out_count,
    output logic                               out_push,
    output abr_pkg::result_t                   out_data
);

    localparam int MEM_DEPTH = 2 * MAX_BLOCK;
    localparam logic [OCNT_W:0] OUT_LIMIT = (OCNT_W + 1)'(OUT_DEPTH);

    logic [abr_pkg::VALUE_W-1:0] mem [MEM_DEPTH];

    logic                        active_reg, active_next;
    abr_pkg::cmd_t               cur_reg;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic                        stg_valid_reg;
    logic                        stg_pass_reg;
    logic                        stg_last_reg;
    logic [abr_pkg::VALUE_W-1:0] stg_value_reg;
    logic [abr_pkg::VALUE_W-1:0] rdata_reg;

    logic [CNT_W-1:0]            cnt;
    logic [CNT_W-1:0]            rd_idx;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        final_elem;
    logic                        is_pass;
    logic                        credit;
    logic                        issue;

    assign cnt        = cur_reg.count[CNT_W-1:0];
    assign final_elem = ((idx_reg + CNT_W'(1)) == cnt);
    assign is_pass    = (cur_reg.kind == abr_pkg::CMD_PASS);
    // Reserve a queue slot for the result already in the read stage.
    assign credit     = (({1'b0, out_count} + (OCNT_W + 1)'(stg_valid_reg)) < OUT_LIMIT);
    assign issue      = active_reg & credit;
    assign cmd_pop    = ~active_reg & ~cmd_empty;
    assign rd_addr    = ADDR_W'(rd_idx[IDX_W-1:0])
                      + (cur_reg.bank ? ADDR_W'(MAX_BLOCK) : ADDR_W'(0));

    always_comb
    begin
        case (cur_reg.kind)
            abr_pkg::CMD_REV: rd_idx = cnt - CNT_W'(1) - idx_reg;
            default:          rd_idx = idx_reg;
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        done.valid  = 1'b0;
        done.bank   = cur_reg.bank;
        if (cmd_pop)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
            if (final_elem)
            begin
                active_next = 1'b0;
                done.valid  = ~is_pass;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            stg_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        if (issue)
        begin
            stg_pass_reg  <= is_pass;
            stg_last_reg  <= cur_reg.last & final_elem;
            stg_value_reg <= cur_reg.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue && !is_pass)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign out_push       = stg_valid_reg;
    assign out_data.value = stg_pass_reg ? stg_value_reg : rdata_reg;
    assign out_data.last  = stg_last_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg |-> out_count < OCNT_W'(OUT_DEPTH))
        else $error("result queue would overflow");

    a_idx_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> idx_reg < cnt)
        else $error("play-out index ran past the block");

    a_done_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done.valid |=> !active_reg)
        else $error("bank released while its command was still active");

endmodule
`default_nettype wire

### rtl/core/alternate_block_reverser_unit.sv
`default_nettype none
// Path: a passed item goes through the command queue, the back part's command register
// and read stage, and the result queue; a reversed block starts after its closing item
// and yields one result a cycle while the result queue has room. Flow: the back part
// takes no new command until its current one is done, and the front stalls while the
// two-entry command queue is full or while the bank it must fill is still playing out.
// Reset: asynchronous, active low; clears queues and block state, block size to 1.
// ---------------------------------------------------------------------------
// alternate_block_reverser_unit: reverses every other block of a sequence
// Odd-numbered blocks come out reversed, even blocks pass; a short trailing
// reversed-phase block comes out in its original order.
// ---------------------------------------------------------------------------
module alternate_block_reverser_unit #(
    parameter int MAX_BLOCK = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic signed [abr_pkg::VALUE_W-1:0]    value,
    input  wire logic                                  last,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic signed [abr_pkg::VALUE_W-1:0]         value_res,
    output logic                                       last_res,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [abr_pkg::SIZE_W-1:0]            cfg_data
);

    localparam int CNT_W      = $clog2(MAX_BLOCK + 1);
    localparam int IDX_W      = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int ADDR_W     = $clog2(2 * MAX_BLOCK);
    localparam int CMD_DEPTH  = 2;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int CMD_BITS   = $bits(abr_pkg::cmd_t);
    localparam int RES_BITS   = $bits(abr_pkg::result_t);

    logic [abr_pkg::SIZE_W-1:0] block_size_reg;
    logic [CNT_W-1:0]           size;

    logic                       cmd_push;
    logic                       cmd_pop;
    logic                       cmd_full;
    logic                       cmd_empty;
    abr_pkg::cmd_t              cmd_in;
    abr_pkg::cmd_t              cmd_out;
    logic [CMD_BITS-1:0]        cmd_out_bits;
    logic [CMD_CNT_W-1:0]       cmd_count;
    abr_pkg::bank_done_t        done;

    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [abr_pkg::VALUE_W-1:0] wr_data;

    logic                       out_push;
    logic                       out_full;
    abr_pkg::result_t           out_in;
    logic [RES_BITS-1:0]        out_bits;
    abr_pkg::result_t           out_head;
    logic [OUT_CNT_W-1:0]       out_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= abr_pkg::SIZE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            block_size_reg <= cfg_data;
        end
    end

    // Zero acts as one, and sizes past the store depth saturate.
    always_comb
    begin
        if (block_size_reg == '0)
        begin
            size = CNT_W'(1);
        end
        else if (int'(block_size_reg) > MAX_BLOCK)
        begin
            size = CNT_W'(MAX_BLOCK);
        end
        else
        begin
            size = CNT_W'(block_size_reg);
        end
    end

    abr_front #(
        .MAX_BLOCK (MAX_BLOCK),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .value    (value),
        .last     (last),
        .full     (full),
        .size     (size),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .done     (done),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    abr_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (CMD_DEPTH),
        .PTR_W (CMD_PTR_W),
        .CNT_W (CMD_CNT_W)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .pop     (cmd_pop),
        .rd_data (cmd_out_bits),
        .empty   (cmd_empty),
        .full    (cmd_full),
        .count   (cmd_count)
    );

    assign cmd_out = abr_pkg::cmd_t'(cmd_out_bits);

    abr_back #(
        .MAX_BLOCK (MAX_BLOCK),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W),
        .ADDR_W    (ADDR_W),
        .OUT_DEPTH (OUT_DEPTH),
        .OCNT_W    (OUT_CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .done      (done),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_count (out_count),
        .out_push  (out_push),
        .out_data  (out_in)
    );

    abr_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (OUT_DEPTH),
        .PTR_W (OUT_PTR_W),
        .CNT_W (OUT_CNT_W)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (out_in),
        .pop     (pop),
        .rd_data (out_bits),
        .empty   (empty),
        .full    (out_full),
        .count   (out_count)
    );

    assign out_head  = abr_pkg::result_t'(out_bits);
    assign value_res = out_head.value;
    assign last_res  = out_head.last;

    a_cmd_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full && cmd_count < CMD_CNT_W'(CMD_DEPTH))
        else $error("request command pushed into a full queue");

    a_out_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full queue");

    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        size != '0 && size <= CNT_W'(MAX_BLOCK))
        else $error("effective block size out of range");

endmodule
`default_nettype wire
